// ----- rtl/core/ipfm_pkg.sv -----
// ----------------------------------------------------------------------------
// ipfm_pkg: shared types and constants of the first-match IP filter
// Rule slot layout, action and register codes, cell and chain control.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfm_pkg;

  localparam int CHAINS          = 3;
  localparam int RULES_PER_CHAIN = 16;
  localparam int REG_CHAINS      = 3;
  localparam int LIVE_CHAINS     = (CHAINS < REG_CHAINS) ? CHAINS : REG_CHAINS;

  localparam int ADDR_W   = 32;
  localparam int POS_W    = 5;
  localparam int MPOS_W   = 4;
  localparam int CNTO_W   = 5;
  localparam int CHAIN_W  = 2;
  localparam int ACTION_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam int IDX_W = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
  localparam int CNT_W = $clog2(RULES_PER_CHAIN + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP   = 3'd0,
    ACT_ADD_HEAD = 3'd1,
    ACT_ADD_TAIL = 3'd2,
    ACT_ADD_POS  = 3'd3,
    ACT_DELETE   = 3'd4,
    ACT_CLEAR    = 3'd5,
    ACT_READ     = 3'd6
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DFLT0  = 2'd0,
    REG_DFLT1  = 2'd1,
    REG_DFLT2  = 2'd2,
    REG_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mask;
    logic              verdict;
  } rule_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             clr;
    logic [CMP_W-1:0] at;
    logic [CMP_W-1:0] pos;
    rule_t            rule;
  } chain_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             hit;
    logic [IDX_W-1:0] hit_pos;
    logic             hit_verdict;
    rule_t            rd;
  } chain_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ip_first_match_filter.sv -----
// ----------------------------------------------------------------------------
// ip_first_match_filter: first-match IPv4 access control lists
// A result is registered in the cycle after its transaction is taken.
// Throughput: one transaction per cycle while no result is stalled; every rule
// cell compares in parallel and a priority encoder per chain picks the first hit.
// Reset: synchronous; chain counts clear, default verdicts go to 0, all chains on.
// Rule slots have no reset; only slots below a chain's count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_first_match_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [1:0]  in_chain,
  input  wire logic [4:0]  in_position,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_mask,
  input  wire logic        in_rule_verdict,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_verdict,
  output logic             out_ok,
  output logic             out_matched,
  output logic [3:0]       out_match_position,
  output logic [4:0]       out_count_now,
  output logic [31:0]      out_read_address,
  output logic [31:0]      out_read_mask,
  output logic             out_read_verdict
);
  import ipfm_pkg::*;

  typedef struct packed {
    logic              verdict;
    logic              ok;
    logic              matched;
    logic [MPOS_W-1:0] match_position;
    logic [CNTO_W-1:0] count_now;
    rule_t             rd;
  } result_t;

  logic [REG_CHAINS-1:0] dflt_r;
  logic [REG_CHAINS-1:0] enable_r;

  logic        accept;
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     res_r;
  result_t     res_nxt;

  action_t     act;
  logic        chain_ok;
  logic        sel_dflt;
  chain_stat_t sel;
  logic        full;
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] at_raw;
  logic [CMP_W-1:0] at;
  logic        do_ins;
  logic        do_del;
  logic        do_clr;

  chain_cmd_t  cmd  [LIVE_CHAINS];
  chain_stat_t stat [LIVE_CHAINS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r   <= '0;
      enable_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DFLT0:  dflt_r[0] <= cfg_wdata[0];
        REG_DFLT1:  dflt_r[1] <= cfg_wdata[0];
        REG_DFLT2:  dflt_r[2] <= cfg_wdata[0];
        REG_ENABLE: enable_r  <= cfg_wdata[REG_CHAINS-1:0];
        default:    ;
      endcase
    end
  end

  assign in_stall      = out_valid_r && out_stall;
  assign accept        = in_valid && !in_stall;
  assign out_valid_nxt = accept || (out_valid_r && out_stall);
  assign act           = action_t'(in_action);

  // select the addressed chain
  always_comb begin
    chain_ok = 1'b0;
    sel_dflt = 1'b0;
    sel      = '0;
    for (int j = 0; j < LIVE_CHAINS; j++) begin
      if (in_chain == CHAIN_W'(j)) begin
        chain_ok = enable_r[j];
        sel_dflt = dflt_r[j];
        sel      = stat[j];
      end
    end
  end

  assign full  = (sel.cnt == CNT_W'(RULES_PER_CHAIN));
  assign cnt_x = CMP_W'(sel.cnt);
  assign pos_x = CMP_W'(in_position);

  always_comb begin
    unique case (act)
      ACT_ADD_HEAD: at_raw = '0;
      ACT_ADD_TAIL: at_raw = cnt_x;
      default:      at_raw = pos_x;
    endcase
  end

  // a position past the end appends
  assign at = (at_raw > cnt_x) ? cnt_x : at_raw;

  always_comb begin
    res_nxt = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    do_clr  = 1'b0;
    if (!chain_ok) begin
      res_nxt.verdict = (act == ACT_LOOKUP);
    end else begin
      res_nxt.count_now = CNTO_W'(sel.cnt);
      unique case (act)
        ACT_LOOKUP: begin
          res_nxt.ok      = 1'b1;
          res_nxt.matched = sel.hit;
          res_nxt.verdict = sel.hit ? sel.hit_verdict : sel_dflt;
          if (sel.hit) begin
            res_nxt.match_position = MPOS_W'(sel.hit_pos);
          end
        end
        ACT_ADD_HEAD, ACT_ADD_TAIL, ACT_ADD_POS: begin
          if (!full) begin
            do_ins            = 1'b1;
            res_nxt.ok        = 1'b1;
            res_nxt.count_now = CNTO_W'(sel.cnt + CNT_W'(1));
          end
        end
        ACT_DELETE: begin
          if (pos_x < cnt_x) begin
            do_del            = 1'b1;
            res_nxt.ok        = 1'b1;
            res_nxt.count_now = CNTO_W'(sel.cnt - CNT_W'(1));
          end
        end
        ACT_CLEAR: begin
          do_clr            = 1'b1;
          res_nxt.ok        = 1'b1;
          res_nxt.count_now = '0;
        end
        ACT_READ: begin
          if (pos_x < cnt_x) begin
            res_nxt.ok = 1'b1;
            res_nxt.rd = sel.rd;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LIVE_CHAINS; g++) begin : g_chain
    logic hit_sel;

    assign hit_sel = accept && chain_ok && (in_chain == CHAIN_W'(g));

    always_comb begin
      cmd[g].ins          = hit_sel && do_ins;
      cmd[g].del          = hit_sel && do_del;
      cmd[g].clr          = hit_sel && do_clr;
      cmd[g].at           = at;
      cmd[g].pos          = pos_x;
      cmd[g].rule.base    = in_address;
      cmd[g].rule.mask    = in_mask;
      cmd[g].rule.verdict = in_rule_verdict;
    end

    ipfm_chain u_chain (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .key   (in_address),
      .stat  (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = res_r.verdict;
  assign out_ok             = res_r.ok;
  assign out_matched        = res_r.matched;
  assign out_match_position = res_r.match_position;
  assign out_count_now      = res_r.count_now;
  assign out_read_address   = res_r.rd.base;
  assign out_read_mask      = res_r.rd.mask;
  assign out_read_verdict   = res_r.rd.verdict;

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_bad_chain_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !chain_ok) |=> (!out_ok && (out_count_now == '0)))
    else $error("disabled or missing chain did not fail");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_ok)
    else $error("match reported on a failed transaction");

endmodule

`default_nettype wire

// ----- rtl/core/ipfm_cell.sv -----
// ----------------------------------------------------------------------------
// ipfm_cell: one rule slot
// Holds a rule, loads a new one or takes its neighbor's, and compares a key.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfm_cell (
  input  wire logic             clk,
  input  wire ipfm_pkg::cell_op_t op,
  input  wire ipfm_pkg::rule_t  new_rule,
  input  wire ipfm_pkg::rule_t  left_rule,
  input  wire ipfm_pkg::rule_t  right_rule,
  input  wire logic [31:0]      key,
  output ipfm_pkg::rule_t       rule_o,
  output logic                  match
);
  import ipfm_pkg::*;

  rule_t rule_r;
  rule_t rule_nxt;

  always_comb begin
    unique case (op)
      CELL_LOAD:  rule_nxt = new_rule;
      CELL_LEFT:  rule_nxt = left_rule;
      CELL_RIGHT: rule_nxt = right_rule;
      default:    rule_nxt = rule_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rule_r <= rule_nxt;
  end

  assign rule_o = rule_r;
  assign match  = ((key ^ rule_r.base) & rule_r.mask) == '0;

endmodule

`default_nettype wire

// ----- rtl/core/ipfm_chain.sv -----
// ----------------------------------------------------------------------------
// ipfm_chain: one ordered rule list
// A row of rule cells with a fill count, first-match priority encoder and
// read-back select. Inserts shift the row up, deletes shift it down.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfm_chain (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ipfm_pkg::chain_cmd_t cmd,
  input  wire logic [31:0]      key,
  output ipfm_pkg::chain_stat_t stat
);
  import ipfm_pkg::*;

  rule_t                      cell_rule [RULES_PER_CHAIN];
  logic [RULES_PER_CHAIN-1:0] cell_match;
  logic [RULES_PER_CHAIN-1:0] hit;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;

  for (genvar i = 0; i < RULES_PER_CHAIN; i++) begin : g_cell
    cell_op_t op;
    rule_t    left_rule;
    rule_t    right_rule;

    always_comb begin
      op = CELL_HOLD;
      if (cmd.ins) begin
        if (CMP_W'(i) == cmd.at) begin
          op = CELL_LOAD;
        end else if (CMP_W'(i) > cmd.at) begin
          op = CELL_LEFT;
        end
      end else if (cmd.del && (CMP_W'(i) >= cmd.pos) && (i < RULES_PER_CHAIN - 1)) begin
        op = CELL_RIGHT;
      end
    end

    if (i > 0) begin : g_left
      assign left_rule = cell_rule[i-1];
    end else begin : g_left_edge
      assign left_rule = cell_rule[i];
    end

    if (i < RULES_PER_CHAIN - 1) begin : g_right
      assign right_rule = cell_rule[i+1];
    end else begin : g_right_edge
      assign right_rule = cell_rule[i];
    end

    ipfm_cell u_cell (
      .clk        (clk),
      .op         (op),
      .new_rule   (cmd.rule),
      .left_rule  (left_rule),
      .right_rule (right_rule),
      .key        (key),
      .rule_o     (cell_rule[i]),
      .match      (cell_match[i])
    );

    assign hit[i] = cell_match[i] && (CNT_W'(i) < cnt_r);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr) begin
      cnt_nxt = '0;
    end else if (cmd.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // lowest matching slot wins
  always_comb begin
    stat.cnt         = cnt_r;
    stat.hit         = |hit;
    stat.hit_pos     = '0;
    stat.hit_verdict = 1'b0;
    stat.rd          = '0;
    for (int i = RULES_PER_CHAIN - 1; i >= 0; i--) begin
      if (hit[i]) begin
        stat.hit_pos     = IDX_W'(i);
        stat.hit_verdict = cell_rule[i].verdict;
      end
    end
    for (int i = 0; i < RULES_PER_CHAIN; i++) begin
      if (CMP_W'(i) == cmd.pos) begin
        stat.rd = cell_rule[i];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RULES_PER_CHAIN))
    else $error("rule count exceeds chain depth");

  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> (cnt_r == '0))
    else $error("clear did not empty the chain");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins && !cmd.clr) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the chain by one");

endmodule

`default_nettype wire

// ----- sim/tb_ip_first_match_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_first_match_filter: self-checking bench for the first-match IP filter
// A directed table runs first, then random edit and lookup traffic. It runs
// under several default-verdict and chain-enable settings and idle patterns.
// Results are compared with a row's given expectation or a shadow copy of the chains.
// ----------------------------------------------------------------------------

module tb_ip_first_match_filter;

  import ipfm_pkg::*;

  localparam logic [2:0] ACT_UNDEFINED = 3'd7;
  localparam int PHASES = 8;

  typedef struct {
    logic [2:0]  action;
    logic [1:0]  chain;
    logic [4:0]  position;
    logic [31:0] address;
    logic [31:0] mask;
    logic        rule_verdict;
  } acl_op_t;

  typedef struct {
    logic        verdict;
    logic        ok;
    logic        matched;
    logic [3:0]  match_position;
    logic [4:0]  count_now;
    logic [31:0] read_address;
    logic [31:0] read_mask;
    logic        read_verdict;
  } acl_reply_t;

  // known: the expected verdict/ok/matched/position/count are given in the row
  typedef struct {
    logic [2:0]  action;
    logic [1:0]  chain;
    logic [4:0]  position;
    logic [31:0] address;
    logic [31:0] mask;
    logic        rule_verdict;
    bit          known;
    logic        verdict;
    logic        ok;
    logic        matched;
    logic [3:0]  match_position;
    logic [4:0]  count_now;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [1:0]  in_chain = '0;
  logic [4:0]  in_position = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_mask = '0;
  logic        in_rule_verdict = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_verdict;
  logic        out_ok;
  logic        out_matched;
  logic [3:0]  out_match_position;
  logic [4:0]  out_count_now;
  logic [31:0] out_read_address;
  logic [31:0] out_read_mask;
  logic        out_read_verdict;

  // shadow of the rule chains and the configuration
  bit [31:0] shadow_base [CHAINS][RULES_PER_CHAIN];
  bit [31:0] shadow_mask [CHAINS][RULES_PER_CHAIN];
  bit        shadow_verd [CHAINS][RULES_PER_CHAIN];
  int        shadow_count [CHAINS];
  bit        dflt_verdict [REG_CHAINS];
  bit [2:0]  chain_on = 3'b111;

  acl_reply_t pending_replies [$];
  int err_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  int idle_src  [4] = '{0, 56, 0, 6};
  int idle_sink [4] = '{0, 0, 56, 6};
  logic [2:0] phase_dflt [PHASES] = '{3'b000, 3'b111, 3'b101, 3'b010,
                                      3'b110, 3'b011, 3'b001, 3'b100};
  logic [2:0] phase_en   [PHASES] = '{3'b111, 3'b111, 3'b010, 3'b000,
                                      3'b101, 3'b111, 3'b110, 3'b111};
  int phase_items [PHASES] = '{200, 180, 170, 40, 180, 190, 180, 200};

  dir_row_t dir_rows [24] = '{
    // empty chain, bad chain, failed edits
    '{ACT_LOOKUP,    2'd0, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 1, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd3, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 1, 0, 0, 4'd0, 5'd0},
    '{ACT_ADD_TAIL,  2'd3, 5'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_READ,      2'd0, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_DELETE,    2'd0, 5'd16, 32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 4'd0, 5'd0},
    // build chain 0; a position past the count appends
    '{ACT_ADD_HEAD,  2'd0, 5'd0,  32'hC0A8_0000, 32'hFFFF_0000, 1'b1, 1, 0, 1, 0, 4'd0, 5'd1},
    '{ACT_ADD_TAIL,  2'd0, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 1, 0, 4'd0, 5'd2},
    '{ACT_ADD_POS,   2'd0, 5'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 1, 0, 4'd0, 5'd3},
    '{ACT_ADD_POS,   2'd0, 5'd1,  32'h0A00_0000, 32'hFF00_0000, 1'b1, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd0, 5'd0,  32'hC0A8_1234, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd0, 5'd0,  32'h0A01_0203, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd0, 5'd0,  32'h0102_0304, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_READ,      2'd0, 5'd3,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_READ,      2'd0, 5'd16, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_DELETE,    2'd0, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_DELETE,    2'd0, 5'd16, 32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_UNDEFINED, 2'd0, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_UNDEFINED, 2'd3, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_CLEAR,     2'd0, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 1, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd1, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1, 0, 1, 0, 4'd0, 5'd0},
    '{ACT_ADD_HEAD,  2'd2, 5'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, 0, 1, 0, 4'd0, 5'd1},
    '{ACT_LOOKUP,    2'd2, 5'd0,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_READ,      2'd2, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0},
    '{ACT_LOOKUP,    2'd2, 5'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 4'd0, 5'd0}
  };

  ip_first_match_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_chain           (in_chain),
    .in_position        (in_position),
    .in_address         (in_address),
    .in_mask            (in_mask),
    .in_rule_verdict    (in_rule_verdict),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_ok             (out_ok),
    .out_matched        (out_matched),
    .out_match_position (out_match_position),
    .out_count_now      (out_count_now),
    .out_read_address   (out_read_address),
    .out_read_mask      (out_read_mask),
    .out_read_verdict   (out_read_verdict)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one transaction to the shadow chains and return the reply it gives.
  function automatic acl_reply_t apply_acl_op(acl_op_t op);
    acl_reply_t r;
    int c;
    int cnt;
    int at;
    bit live;
    r = '{default: '0};
    c = int'(op.chain);
    live = (c < CHAINS) && (c < REG_CHAINS);
    if (live) live = chain_on[c];
    if (!live) begin
      r.verdict = (op.action == ACT_LOOKUP);
      return r;
    end
    cnt = shadow_count[c];
    case (op.action)
      ACT_LOOKUP: begin
        r.verdict = dflt_verdict[c];
        r.ok = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          if (((op.address ^ shadow_base[c][i]) & shadow_mask[c][i]) == 32'h0) begin
            r.verdict = shadow_verd[c][i];
            r.matched = 1'b1;
            r.match_position = 4'(i);
            break;
          end
        end
      end
      ACT_ADD_HEAD, ACT_ADD_TAIL, ACT_ADD_POS: begin
        if (cnt < RULES_PER_CHAIN) begin
          at = (op.action == ACT_ADD_HEAD) ? 0 :
               (op.action == ACT_ADD_TAIL) ? cnt : int'(op.position);
          if (at > cnt) at = cnt;
          for (int i = cnt; i > at; i--) begin
            shadow_base[c][i] = shadow_base[c][i-1];
            shadow_mask[c][i] = shadow_mask[c][i-1];
            shadow_verd[c][i] = shadow_verd[c][i-1];
          end
          shadow_base[c][at] = op.address;
          shadow_mask[c][at] = op.mask;
          shadow_verd[c][at] = op.rule_verdict;
          cnt++;
          shadow_count[c] = cnt;
          r.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (int'(op.position) < cnt) begin
          for (int i = int'(op.position); i + 1 < cnt; i++) begin
            shadow_base[c][i] = shadow_base[c][i+1];
            shadow_mask[c][i] = shadow_mask[c][i+1];
            shadow_verd[c][i] = shadow_verd[c][i+1];
          end
          cnt--;
          shadow_count[c] = cnt;
          r.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        cnt = 0;
        shadow_count[c] = 0;
        r.ok = 1'b1;
      end
      ACT_READ: begin
        if (int'(op.position) < cnt) begin
          r.ok = 1'b1;
          r.read_address = shadow_base[c][op.position[3:0]];
          r.read_mask = shadow_mask[c][op.position[3:0]];
          r.read_verdict = shadow_verd[c][op.position[3:0]];
        end
      end
      default: ;
    endcase
    r.count_now = 5'(cnt);
    return r;
  endfunction

  // Mostly valid chains; lookups are steered onto stored rules most of the time.
  function automatic acl_op_t make_random_op();
    acl_op_t op;
    int pick;
    int c;
    int len;
    int k;
    pick = $urandom_range(99);
    c = ($urandom_range(99) < 6) ? 3 : $urandom_range(CHAINS - 1);
    op.chain = 2'(c);
    op.address = $urandom;
    op.rule_verdict = 1'($urandom_range(1));
    case ($urandom_range(3))
      0, 1: begin
        len = $urandom_range(32);
        op.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
      end
      2: op.mask = $urandom;
      default: op.mask = 32'hFFFF_FFFF << $urandom_range(8);
    endcase
    if (c < CHAINS && shadow_count[c] > 0 && $urandom_range(99) < 70)
      op.position = 5'($urandom_range(shadow_count[c] - 1));
    else
      op.position = 5'($urandom_range(RULES_PER_CHAIN));
    if (pick < 40)      op.action = ACT_LOOKUP;
    else if (pick < 49) op.action = ACT_ADD_HEAD;
    else if (pick < 59) op.action = ACT_ADD_TAIL;
    else if (pick < 69) op.action = ACT_ADD_POS;
    else if (pick < 79) op.action = ACT_DELETE;
    else if (pick < 96) op.action = ACT_READ;
    else if (pick < 98) op.action = ACT_CLEAR;
    else                op.action = ACT_UNDEFINED;
    if (op.action == ACT_LOOKUP && c < CHAINS && shadow_count[c] > 0 &&
        $urandom_range(99) < 70) begin
      k = $urandom_range(shadow_count[c] - 1);
      op.address = (shadow_base[c][k] & shadow_mask[c][k]) |
                   (op.address & ~shadow_mask[c][k]);
    end
    return op;
  endfunction

  // Leaves in_valid high on return; the caller lowers it when traffic stops.
  task automatic send_op(input acl_op_t op, input bit known, input acl_reply_t want);
    acl_reply_t guess;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= op.action;
    in_chain <= op.chain;
    in_position <= op.position;
    in_address <= op.address;
    in_mask <= op.mask;
    in_rule_verdict <= op.rule_verdict;
    do @(posedge clk); while (in_stall);
    guess = apply_acl_op(op);
    pending_replies.push_back(known ? want : guess);
  endtask

  task automatic program_regs(input logic [2:0] dflts, input logic [2:0] en);
    for (int r = REG_DFLT0; r <= REG_ENABLE; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(r);
      cfg_wdata <= (r == REG_ENABLE) ? en : {2'b00, dflts[r]};
      @(posedge clk);
      if (r == REG_ENABLE) chain_on = en;
      else dflt_verdict[r] = dflts[r];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_replies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_replies.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, pending_replies.size());
      pending_replies.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 200)
        $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_reply();
    acl_reply_t want;
    if (pending_replies.size() == 0) begin
      err_count++;
      if (err_count <= 200)
        $display("%0t: unexpected transaction, expected none, actual verdict %0b ok %0b",
                 $time, out_verdict, out_ok);
      return;
    end
    want = pending_replies.pop_front();
    check_field("verdict", 32'(want.verdict), 32'(out_verdict));
    check_field("ok", 32'(want.ok), 32'(out_ok));
    check_field("matched", 32'(want.matched), 32'(out_matched));
    check_field("match_position", 32'(want.match_position), 32'(out_match_position));
    check_field("count_now", 32'(want.count_now), 32'(out_count_now));
    check_field("read_address", want.read_address, out_read_address);
    check_field("read_mask", want.read_mask, out_read_mask);
    check_field("read_verdict", 32'(want.read_verdict), 32'(out_read_verdict));
  endtask

  // Sample the result channel, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_reply();
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    acl_op_t op;
    acl_reply_t want;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      op = '{dir_rows[k].action, dir_rows[k].chain, dir_rows[k].position,
             dir_rows[k].address, dir_rows[k].mask, dir_rows[k].rule_verdict};
      want = '{default: '0};
      want.verdict = dir_rows[k].verdict;
      want.ok = dir_rows[k].ok;
      want.matched = dir_rows[k].matched;
      want.match_position = dir_rows[k].match_position;
      want.count_now = dir_rows[k].count_now;
      send_op(op, dir_rows[k].known, want);
    end
    in_valid <= 1'b0;
    wait_drained();

    want = '{default: '0};
    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct = idle_src[ph % 4];
      sink_stall_pct = idle_sink[ph % 4];
      program_regs(phase_dflt[ph], phase_en[ph]);
      for (int n = 0; n < phase_items[ph]; n++)
        send_op(make_random_op(), 1'b0, want);
      in_valid <= 1'b0;
      wait_drained();
    end

    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- ip_first_match_filter.f -----
rtl/core/ipfm_pkg.sv
rtl/core/ipfm_cell.sv
rtl/core/ipfm_chain.sv
rtl/core/ip_first_match_filter.sv
sim/tb_ip_first_match_filter.sv
